// ----- src/tkst_pkg.sv -----
// Shared types, codes and the name-tag shaping function of the top-k score table.
package tkst_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned NAME_BYTES = 8;

  localparam int unsigned SCORE_W  = 32;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned COUNT_W  = 5;
  // Wide enough for a placement count up to the largest table (64 entries).
  localparam int unsigned PLACED_W = 7;

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [SCORE_W-1:0] new_score;
    logic [NAME_W-1:0]  entry_name;
    logic [RANK_W-1:0]  read_rank;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [RANK_W-1:0]  placed_rank;
    logic [COUNT_W-1:0] entry_count;
    logic               read_valid;
    logic [SCORE_W-1:0] read_score;
    logic [NAME_W-1:0]  read_name;
  } out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               opcode;
    logic               insert;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  read_rank;
  } cmd_t;

  // Probe that walks the row, one cell per cycle.
  typedef struct packed {
    logic                vld;
    logic                rvalid;
    logic [PLACED_W-1:0] placed;
    logic [SCORE_W-1:0]  score;
    logic [NAME_W-1:0]   name;
  } pkt_t;

  // Keep the low nbytes bytes, cut the tag at its first zero byte.
  function automatic logic [NAME_W-1:0] shape_tag(logic [NAME_W-1:0] raw,
                                                  int unsigned nbytes);
    logic [NAME_W-1:0] tag;
    logic              alive;
    tag   = '0;
    alive = 1'b1;
    for (int unsigned i = 0; i < NAME_W / 8; i++) begin
      alive = alive && (i < nbytes) && (raw[8*i +: 8] != 8'd0);
      if (alive) begin
        tag[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return tag;
  endfunction

endpackage

// ----- src/tkst_cell.sv -----
// One rank slot of the score table: holds an entry and forwards the walking probe.
module tkst_cell #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned CntW  = 5,
  parameter int unsigned NameW = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tkst_pkg::cmd_t           cmd_i,
  input  logic [CntW-1:0]          count_i,
  input  logic [NameW-1:0]         new_name_i,
  input  logic                     left_pass_i,
  input  logic [tkst_pkg::SCORE_W-1:0] left_score_i,
  input  logic [NameW-1:0]         left_name_i,
  input  tkst_pkg::pkt_t           pkt_i,
  output logic                     pass_o,
  output logic [tkst_pkg::SCORE_W-1:0] score_o,
  output logic [NameW-1:0]         name_o,
  output tkst_pkg::pkt_t           pkt_o
);
  import tkst_pkg::*;

  localparam bit Reach = (Idx < (1 << RANK_W));

  logic [SCORE_W-1:0] score_q;
  logic [NameW-1:0]   name_q;
  logic               occ;
  logic               hit;
  pkt_t               pkt_d, pkt_q;

  assign occ    = CntW'(Idx) < count_i;
  // Entry stays ahead of the new score: occupied and not lower.
  assign pass_o = occ && (score_q >= cmd_i.score);
  assign hit    = Reach && occ && (cmd_i.opcode == OP_READ) &&
                  (cmd_i.read_rank == RANK_W'(Idx));

  assign score_o = score_q;
  assign name_o  = name_q;
  assign pkt_o   = pkt_q;

  // Take the new entry at the insertion point, shift from the left neighbor below it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !pass_o) begin
      if (left_pass_i) begin
        score_q <= cmd_i.score;
        name_q  <= new_name_i;
      end else begin
        score_q <= left_score_i;
        name_q  <= left_name_i;
      end
    end
  end

  always_comb begin
    pkt_d = pkt_i;
    if (pkt_i.vld) begin
      if (pass_o) begin
        pkt_d.placed = pkt_i.placed + PLACED_W'(1);
      end
      if (hit) begin
        pkt_d.rvalid = 1'b1;
        pkt_d.score  = score_q;
        pkt_d.name   = NAME_W'(name_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

endmodule

// ----- src/top_k_sorted_score_table.sv -----
// Top-k score table: a row of rank cells kept in descending score order.
//
// Usage: the input channel (in_valid_i / in_ready_o / in_data_i) carries one
// command per transfer: a submit of a score with a name tag, or a read of the
// entry at a rank. Every command yields exactly one result on the output
// channel (out_valid_o / out_ready_i / out_data_o).
// A command enters and a probe walks the row of cells, one cell per cycle,
// counting the entries that stay ahead of the new score and picking up the
// entry at the read rank. At the end of the row the insert is committed,
// every cell below the insertion point taking its left neighbor in the same cycle.
// The block takes one command at a time: a new command is taken only after
// the walk through the row for the last one is done and its result has
// left the S_EMIT state.
// A finished result sits in the output register; a new command is taken
// while it waits. If the receiver stalls, the next result holds in the
// block until the output register is free.
// Reset empties the table (fill count zero) and clears the output channel.
module top_k_sorted_score_table #(
  parameter int unsigned Entries   = tkst_pkg::ENTRIES,
  parameter int unsigned NameBytes = tkst_pkg::NAME_BYTES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tkst_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tkst_pkg::out_t out_data_o
);
  import tkst_pkg::*;

  localparam int unsigned CntW  = $clog2(Entries + 1);
  localparam int unsigned NameW = 8 * NameBytes;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic               start_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               op_q;
  logic [SCORE_W-1:0] score_q;
  logic [RANK_W-1:0]  rank_q;
  logic [NameW-1:0]   name_q;
  out_t               res_q, res_d;
  out_t               out_q;
  logic               out_valid_q;

  cmd_t               cmd;
  pkt_t               pkt_head;
  pkt_t               pkt_tail;
  logic               walk_done;
  logic               take_in;
  logic               accepted;
  logic               emit;

  logic [Entries-1:0]  pass_w;
  logic [SCORE_W-1:0]  score_w [Entries];
  logic [NameW-1:0]    name_w  [Entries];
  pkt_t                pkt_w   [Entries];

  assign in_ready_o  = (state_q == S_IDLE);
  assign take_in     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  // Move the finished result into the output register once it is free.
  assign emit        = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  assign pkt_tail  = pkt_w[Entries-1];
  assign walk_done = (state_q == S_WALK) && pkt_tail.vld;
  // Table full and the new score not above the lowest: last cell still passes.
  assign accepted  = (op_q == OP_SUBMIT) && !pass_w[Entries-1];

  always_comb begin
    cmd.opcode    = op_q;
    cmd.insert    = walk_done && accepted;
    cmd.score     = score_q;
    cmd.read_rank = rank_q;
  end

  always_comb begin
    pkt_head     = '0;
    pkt_head.vld = start_q;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.insert && (count_q != CntW'(Entries))) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    res_d             = '0;
    res_d.accepted    = accepted;
    res_d.placed_rank = accepted ? RANK_W'(pkt_tail.placed) : '0;
    res_d.entry_count = COUNT_W'(count_d);
    res_d.read_valid  = pkt_tail.rvalid;
    res_d.read_score  = pkt_tail.score;
    res_d.read_name   = pkt_tail.name;
  end

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    logic               left_pass;
    logic [SCORE_W-1:0] left_score;
    logic [NameW-1:0]   left_name;
    pkt_t               left_pkt;

    if (i == 0) begin : g_head
      assign left_pass  = 1'b1;
      assign left_score = score_q;
      assign left_name  = name_q;
      assign left_pkt   = pkt_head;
    end else begin : g_link
      assign left_pass  = pass_w[i-1];
      assign left_score = score_w[i-1];
      assign left_name  = name_w[i-1];
      assign left_pkt   = pkt_w[i-1];
    end

    tkst_cell #(
      .Idx  (i),
      .CntW (CntW),
      .NameW(NameW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .new_name_i  (name_q),
      .left_pass_i (left_pass),
      .left_score_i(left_score),
      .left_name_i (left_name),
      .pkt_i       (left_pkt),
      .pass_o      (pass_w[i]),
      .score_o     (score_w[i]),
      .name_o      (name_w[i]),
      .pkt_o       (pkt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      count_q     <= '0;
      op_q        <= OP_SUBMIT;
      score_q     <= '0;
      rank_q      <= '0;
      name_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= take_in;
      count_q <= count_d;
      if (emit) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (take_in) begin
            op_q    <= in_data_i.opcode;
            score_q <= in_data_i.new_score;
            rank_q  <= in_data_i.read_rank;
            name_q  <= NameW'(shape_tag(in_data_i.entry_name, NameBytes));
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            res_q   <= res_d;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold the result until the output register is free.
          if (emit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
